### hdl/fault_injection_controller_macros.svh
// assertion macros shared by the checker
`ifndef FAULT_INJECTION_CONTROLLER_MACROS_SVH
`define FAULT_INJECTION_CONTROLLER_MACROS_SVH

// checked only out of reset
`define FIC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define FIC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/fic_pkg.sv
`default_nettype none
package fic_pkg;

	// payload sizing
	localparam int LEN_W = 24;
	localparam int RATE_W = 7;
	localparam int MS_W = 20;
	localparam int TIME_W = 32;

	localparam logic [LEN_W-1:0] SET_MIN_BYTES = LEN_W'(6);
	localparam logic [LEN_W-1:0] CLEAR_MIN_BYTES = LEN_W'(2);
	localparam logic [31:0] MAX_RECONNECT_MS = 32'd600000;
	localparam logic [9:0] US_PER_MS = 10'd1000;
	localparam logic [RATE_W-1:0] FULL_PERCENT = RATE_W'(100);
	localparam logic [31:0] FULL_PERCENT_ARG = 32'd100;
	localparam logic [31:0] MAX_KEEP_PERCENT = 32'd99;
	localparam logic [LEN_W-1:0] MIN_KEPT_BYTES = LEN_W'(2);

	// divide by 100: drop two low bits, then multiply by ceil(2^34 / 25)
	localparam int DIV_SHIFT = 34;
	localparam logic [29:0] DIV_MULT = 30'(((64'd1 << DIV_SHIFT) + 64'd24) / 64'd25);

	// commands
	localparam logic [1:0] CMD_SET = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;
	localparam logic [1:0] CMD_FRAME = 2'd3;

	// fault codes
	localparam logic [7:0] CODE_ALL = 8'd0;
	localparam logic [7:0] CODE_DETACH = 8'd1;
	localparam logic [7:0] CODE_DROP = 8'd2;
	localparam logic [7:0] CODE_PARTIAL = 8'd3;

	// ack status
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_ARG = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;

	// queue depths
	localparam int OPQ_DEPTH = 4;
	localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
	localparam int RESQ_DEPTH = 4;
	localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);

	// classified item, front to back
	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] code;
		logic short_len;
		logic arg_ok;
		logic [RATE_W-1:0] rate;
		logic [TIME_W-1:0] deadline;
		logic [LEN_W-1:0] len;
		logic [TIME_W-1:0] now;
	} op_t;

	// result item
	typedef struct packed {
		logic ack_valid;
		logic [7:0] ack_code;
		logic [1:0] ack_status;
		logic link_attached;
		logic drop_frame;
		logic [LEN_W-1:0] effective_length;
	} result_t;

endpackage
`default_nettype wire

### hdl/fic_front.sv
`default_nettype none
module fic_front import fic_pkg::*; (
	input wire logic push,
	input wire logic [1:0] command,
	input wire logic [7:0] fault_id,
	input wire logic [31:0] argument,
	input wire logic [LEN_W-1:0] length,
	input wire logic [TIME_W-1:0] now_us,
	input wire logic q_full,
	output logic full,
	output logic q_wr,
	output op_t q_op
);

	logic [29:0] delay_us;
	logic [TIME_W-1:0] due;
	logic [LEN_W-1:0] min_len;

	// deadline for a timed reconnect, wraps modulo 2^32
	assign delay_us = 30'(argument[MS_W-1:0]) * 30'(US_PER_MS);
	assign due = now_us + TIME_W'(delay_us);
	assign min_len = (command == CMD_SET) ? SET_MIN_BYTES : CLEAR_MIN_BYTES;

	always_comb begin
		q_op.cmd = command;
		q_op.code = fault_id;
		q_op.short_len = (length < min_len);
		q_op.rate = argument[RATE_W-1:0];
		q_op.deadline = (argument == 32'd0) ? '0 : due;
		q_op.len = length;
		q_op.now = now_us;
		unique case (fault_id)
			CODE_DETACH: q_op.arg_ok = (argument <= MAX_RECONNECT_MS);
			CODE_DROP: q_op.arg_ok = (argument != 32'd0) && (argument <= FULL_PERCENT_ARG);
			CODE_PARTIAL: q_op.arg_ok = (argument != 32'd0) && (argument <= MAX_KEEP_PERCENT);
			default: q_op.arg_ok = 1'b0;
		endcase
	end

	assign full = q_full;
	assign q_wr = push && !q_full;

endmodule
`default_nettype wire

### hdl/fic_op_queue.sv
`default_nettype none
module fic_op_queue import fic_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr,
	input wire op_t wr_op,
	input wire logic rd,
	output op_t rd_op,
	output logic full,
	output logic empty
);

	op_t mem_q [OPQ_DEPTH];
	logic [OPQ_PTR_W-1:0] wr_ptr_q;
	logic [OPQ_PTR_W-1:0] rd_ptr_q;
	logic [OPQ_PTR_W:0] count_q;
	logic do_wr;
	logic do_rd;

	assign full = (count_q == (OPQ_PTR_W+1)'(OPQ_DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rd_op = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### hdl/fic_back.sv
`default_nettype none
module fic_back import fic_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic op_empty,
	input wire op_t op,
	output logic op_rd,
	input wire logic pop,
	output logic empty,
	output result_t res
);

	// fault state
	logic detached_q;
	logic [TIME_W-1:0] deadline_q;
	logic [RATE_W-1:0] drop_rate_q;
	logic [RATE_W-1:0] drop_accum_q;
	logic [RATE_W-1:0] keep_rate_q;

	logic detached_d;
	logic [TIME_W-1:0] deadline_d;
	logic [RATE_W-1:0] drop_rate_d;
	logic [RATE_W-1:0] drop_accum_d;
	logic [RATE_W-1:0] keep_rate_d;
	result_t res_d;
	logic [RATE_W:0] accum_sum;
	logic [TIME_W-1:0] since_due;

	// pipeline
	logic v_s1;
	result_t res_s1;
	logic trunc_s1;
	logic [LEN_W+RATE_W-1:0] prod_s1;
	logic v_s2;
	result_t res_s2;
	logic trunc_s2;
	logic [LEN_W-1:0] quot_s2;
	logic [58:0] div_prod;

	// result queue
	result_t resq_q [RESQ_DEPTH];
	logic [RESQ_PTR_W-1:0] wr_ptr_q;
	logic [RESQ_PTR_W-1:0] rd_ptr_q;
	logic [RESQ_PTR_W:0] count_q;
	logic [RESQ_PTR_W:0] in_use;
	logic res_rd;
	result_t res_wr;

	// take an item only when the result queue has room for everything in flight
	assign in_use = count_q + (RESQ_PTR_W+1)'(v_s1) + (RESQ_PTR_W+1)'(v_s2);
	assign op_rd = !op_empty && (in_use < (RESQ_PTR_W+1)'(RESQ_DEPTH));

	assign accum_sum = {1'b0, drop_accum_q} + {1'b0, drop_rate_q};
	assign since_due = op.now - deadline_q;

	always_comb begin
		detached_d = detached_q;
		deadline_d = deadline_q;
		drop_rate_d = drop_rate_q;
		drop_accum_d = drop_accum_q;
		keep_rate_d = keep_rate_q;
		res_d = '0;
		unique case (op.cmd)
			CMD_SET: begin
				res_d.ack_valid = 1'b1;
				if (op.short_len) begin
					res_d.ack_status = ST_BAD_ARG;
				end else begin
					res_d.ack_code = op.code;
					unique case (op.code)
						CODE_DETACH: begin
							if (!op.arg_ok) begin
								res_d.ack_status = ST_BAD_ARG;
							end else begin
								detached_d = 1'b1;
								deadline_d = op.deadline;
							end
						end
						CODE_DROP: begin
							if (!op.arg_ok) begin
								res_d.ack_status = ST_BAD_ARG;
							end else begin
								drop_rate_d = op.rate;
								drop_accum_d = '0;
							end
						end
						CODE_PARTIAL: begin
							if (!op.arg_ok) begin
								res_d.ack_status = ST_BAD_ARG;
							end else begin
								keep_rate_d = op.rate;
							end
						end
						default: res_d.ack_status = ST_UNKNOWN;
					endcase
				end
			end
			CMD_CLEAR: begin
				res_d.ack_valid = 1'b1;
				if (op.short_len) begin
					res_d.ack_status = ST_BAD_ARG;
				end else begin
					res_d.ack_code = op.code;
					if (op.code == CODE_ALL || op.code == CODE_DETACH) begin
						detached_d = 1'b0;
						if (detached_q) begin
							deadline_d = '0;
						end
					end
					if (op.code == CODE_ALL || op.code == CODE_DROP) begin
						drop_rate_d = '0;
						drop_accum_d = '0;
					end
					if (op.code == CODE_ALL || op.code == CODE_PARTIAL) begin
						keep_rate_d = FULL_PERCENT;
					end
				end
			end
			CMD_TICK: begin
				// reattach once the deadline is reached, compared with wrap
				if (detached_q && deadline_q != '0 && !since_due[TIME_W-1]) begin
					detached_d = 1'b0;
					deadline_d = '0;
				end
			end
			default: begin
				if (drop_rate_q != '0) begin
					if (accum_sum >= {1'b0, FULL_PERCENT}) begin
						drop_accum_d = RATE_W'(accum_sum - {1'b0, FULL_PERCENT});
						res_d.drop_frame = 1'b1;
					end else begin
						drop_accum_d = accum_sum[RATE_W-1:0];
					end
				end
				res_d.effective_length = op.len;
			end
		endcase
		res_d.link_attached = !detached_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detached_q <= 1'b0;
			deadline_q <= '0;
			drop_rate_q <= '0;
			drop_accum_q <= '0;
			keep_rate_q <= FULL_PERCENT;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= op_rd;
			v_s2 <= v_s1;
			if (op_rd) begin
				detached_q <= detached_d;
				deadline_q <= deadline_d;
				drop_rate_q <= drop_rate_d;
				drop_accum_q <= drop_accum_d;
				keep_rate_q <= keep_rate_d;
			end
		end
	end

	// stage 1: byte count times keep percent
	always_ff @(posedge clk) begin
		res_s1 <= res_d;
		trunc_s1 <= (op.cmd == CMD_FRAME) && (keep_rate_q < FULL_PERCENT);
		prod_s1 <= (LEN_W+RATE_W)'(op.len) * (LEN_W+RATE_W)'(keep_rate_q);
	end

	// stage 2: divide by 100 through the reciprocal
	assign div_prod = 59'(prod_s1[LEN_W+RATE_W-1:2]) * 59'(DIV_MULT);

	always_ff @(posedge clk) begin
		res_s2 <= res_s1;
		trunc_s2 <= trunc_s1;
		quot_s2 <= div_prod[DIV_SHIFT+LEN_W-1:DIV_SHIFT];
	end

	always_comb begin
		res_wr = res_s2;
		if (trunc_s2) begin
			res_wr.effective_length = (quot_s2 < MIN_KEPT_BYTES) ? MIN_KEPT_BYTES : quot_s2;
		end
	end

	assign empty = (count_q == '0);
	assign res_rd = pop && !empty;
	assign res = resq_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (v_s2) begin
			resq_q[wr_ptr_q] <= res_wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (v_s2) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (res_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (v_s2 && !res_rd) begin
				count_q <= count_q + 1'b1;
			end else if (res_rd && !v_s2) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### hdl/fault_injection_controller.sv
// fault-injection controller for a camera link
// input channel: push/full; an item (command, fault_id, argument, length,
//   now_us) is taken at a clock edge with push high and full low
// result channel: empty/pop; the oldest result sits on the result ports while
//   empty is low and leaves at an edge with pop high and empty low
// every item gives exactly one result: set and clear give an ack, tick
//   may reattach the link, frame events give drop_frame and effective_length
// an item passes through the op queue, the execute stage and the divide stage
//   before its result enters the result queue
// throughput: one item per cycle while the result queue has room, set by the
//   execute stage owning the fault state; both channels may run every cycle at once
// the front classifies and range-checks into a four-entry op queue; the back
//   updates fault state, scales frame lengths and fills a four-entry result queue
// when the receiver stalls, the result queue fills, the back stops taking ops,
//   the op queue fills and full rises; no item is lost
// arst_n low: queues empty, link attached, no faults armed, keep percent 100
`default_nettype none
module fault_injection_controller import fic_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [1:0] command,
	input wire logic [7:0] fault_id,
	input wire logic [31:0] argument,
	input wire logic [LEN_W-1:0] length,
	input wire logic [TIME_W-1:0] now_us,
	output logic empty,
	input wire logic pop,
	output logic ack_valid,
	output logic [7:0] ack_code,
	output logic [1:0] ack_status,
	output logic link_attached,
	output logic drop_frame,
	output logic [LEN_W-1:0] effective_length
);

	// front to op queue
	logic opq_wr;
	op_t opq_wr_op;
	logic opq_full;

	// op queue to back
	logic opq_rd;
	op_t opq_rd_op;
	logic opq_empty;

	result_t res;

	fic_front u_front (
		.push(push),
		.command(command),
		.fault_id(fault_id),
		.argument(argument),
		.length(length),
		.now_us(now_us),
		.q_full(opq_full),
		.full(full),
		.q_wr(opq_wr),
		.q_op(opq_wr_op)
	);

	fic_op_queue u_op_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(opq_wr),
		.wr_op(opq_wr_op),
		.rd(opq_rd),
		.rd_op(opq_rd_op),
		.full(opq_full),
		.empty(opq_empty)
	);

	fic_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.op_empty(opq_empty),
		.op(opq_rd_op),
		.op_rd(opq_rd),
		.pop(pop),
		.empty(empty),
		.res(res)
	);

	// result fields out to their own ports
	assign ack_valid = res.ack_valid;
	assign ack_code = res.ack_code;
	assign ack_status = res.ack_status;
	assign link_attached = res.link_attached;
	assign drop_frame = res.drop_frame;
	assign effective_length = res.effective_length;

endmodule
`default_nettype wire

### hdl/fic_checker.sv
`default_nettype none
`include "fault_injection_controller_macros.svh"
module fic_checker import fic_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic empty,
	input wire logic pop,
	input wire logic ack_valid,
	input wire logic [7:0] ack_code,
	input wire logic [1:0] ack_status,
	input wire logic drop_frame,
	input wire logic [LEN_W-1:0] effective_length
);

	`FIC_ASSERT_ALWAYS(a_reset_empty, (!arst_n |=> empty), "result queue not empty in reset")
	`FIC_ASSERT(a_result_holds, (!empty && !pop |=> !empty), "waiting result vanished")
	`FIC_ASSERT(a_no_ack_clean, (!empty && !ack_valid |-> ack_code == CODE_ALL && ack_status == ST_OK), "stray ack fields")
	`FIC_ASSERT(a_ack_no_frame, (!empty && ack_valid |-> !drop_frame && effective_length == '0), "ack with frame fields")

endmodule

bind fault_injection_controller fic_checker u_fic_checker (.*);
`default_nettype wire
